// ===== src/assert_macros.svh =====
// Assertion shorthands for the RTL; rect_subtract_largest_piece.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rsl_pkg.sv =====
package rsl_pkg;

	// Width of a coordinate as the datapath sees it; the ports stay 32 bits.
	localparam int COORD_BITS = 32;
	localparam int IO_BITS    = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SPAN_BITS  = COORD_BITS - 1;
	localparam int PROD_BITS  = 2 * SPAN_BITS;

	typedef logic signed [IO_BITS-1:0]    io_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [SPAN_BITS-1:0]         span_t;
	typedef logic [PROD_BITS-1:0]         prod_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} rect_t;

	// Result of the geometry check on one rectangle pair.
	typedef struct packed {
		logic  pass;    // both non-empty and overlapping
		logic  none;    // B covers A: no strip left
		logic  single;  // exactly one strip left
		span_t aw;
		span_t ah;
		span_t nl;
		span_t nr;
		span_t nt;
		span_t nb;
	} geom_t;

	function automatic coord_t coord_in(io_t x);
		return coord_t'(x[COORD_BITS-1:0]);
	endfunction

	function automatic io_t coord_out(coord_t c);
		return IO_BITS'(c);
	endfunction

endpackage

// ===== src/rsl_ifs.sv =====
interface rsl_pair_if;
	import rsl_pkg::*;

	logic valid;
	logic ready;
	io_t  a_left;
	io_t  a_top;
	io_t  a_right;
	io_t  a_bottom;
	io_t  b_left;
	io_t  b_top;
	io_t  b_right;
	io_t  b_bottom;

	modport source (output valid, a_left, a_top, a_right, a_bottom,
		b_left, b_top, b_right, b_bottom, input ready);
	modport sink (input valid, a_left, a_top, a_right, a_bottom,
		b_left, b_top, b_right, b_bottom, output ready);
endinterface

interface rsl_piece_if;
	import rsl_pkg::*;

	logic valid;
	logic ready;
	io_t  out_left;
	io_t  out_top;
	io_t  out_right;
	io_t  out_bottom;
	logic is_exact;

	modport source (output valid, out_left, out_top, out_right, out_bottom, is_exact,
		input ready);
	modport sink (input valid, out_left, out_top, out_right, out_bottom, is_exact,
		output ready);
endinterface

// ===== src/rsl_geom.sv =====
module rsl_geom (
	input  rsl_pkg::rect_t a,
	input  rsl_pkg::rect_t b,
	output rsl_pkg::geom_t geom
);
	import rsl_pkg::*;

	coord_t al, at, ar, ab, bl, bt, br, bb;
	diff_t  wa, ha, wb, hb;
	diff_t  dl, dr, dt, db;
	logic   ne_a, ne_b, ov_x, ov_y;
	logic   gl, gr, gt, gb;
	coord_t max_l, min_r, max_t, min_b;

	assign al = a.left;
	assign at = a.top;
	assign ar = a.right;
	assign ab = a.bottom;
	assign bl = b.left;
	assign bt = b.top;
	assign br = b.right;
	assign bb = b.bottom;

	assign wa = DIFF_BITS'(ar) - DIFF_BITS'(al);
	assign ha = DIFF_BITS'(ab) - DIFF_BITS'(at);
	assign wb = DIFF_BITS'(br) - DIFF_BITS'(bl);
	assign hb = DIFF_BITS'(bb) - DIFF_BITS'(bt);

	// A usable extent is positive and below half the coordinate range, so its
	// top two bits are clear and the rest is not zero.
	assign ne_a = (wa[DIFF_BITS-1 -: 2] == 2'b00) && (wa[SPAN_BITS-1:0] != '0) &&
		(ha[DIFF_BITS-1 -: 2] == 2'b00) && (ha[SPAN_BITS-1:0] != '0);
	assign ne_b = (wb[DIFF_BITS-1 -: 2] == 2'b00) && (wb[SPAN_BITS-1:0] != '0) &&
		(hb[DIFF_BITS-1 -: 2] == 2'b00) && (hb[SPAN_BITS-1:0] != '0);

	assign max_l = (al > bl) ? al : bl;
	assign min_r = (ar < br) ? ar : br;
	assign max_t = (at > bt) ? at : bt;
	assign min_b = (ab < bb) ? ab : bb;
	assign ov_x  = max_l < min_r;
	assign ov_y  = max_t < min_b;

	assign gl = bl > al;
	assign gr = ar > br;
	assign gt = bt > at;
	assign gb = ab > bb;

	assign dl = DIFF_BITS'(bl) - DIFF_BITS'(al);
	assign dr = DIFF_BITS'(ar) - DIFF_BITS'(br);
	assign dt = DIFF_BITS'(bt) - DIFF_BITS'(at);
	assign db = DIFF_BITS'(ab) - DIFF_BITS'(bb);

	always_comb begin
		geom.pass   = ne_a && ne_b && ov_x && ov_y;
		geom.none   = !(gl || gr || gt || gb);
		geom.single = $onehot({gl, gr, gt, gb});
		geom.aw     = wa[SPAN_BITS-1:0];
		geom.ah     = ha[SPAN_BITS-1:0];
		geom.nl     = gl ? dl[SPAN_BITS-1:0] : '0;
		geom.nr     = gr ? dr[SPAN_BITS-1:0] : '0;
		geom.nt     = gt ? dt[SPAN_BITS-1:0] : '0;
		geom.nb     = gb ? db[SPAN_BITS-1:0] : '0;
	end

endmodule

// ===== src/rect_subtract_largest_piece.sv =====
// Largest piece of rectangle A that lies outside rectangle B.
// The pair channel carries one request per rectangle pair (A and B, left and
// top inclusive, right and bottom exclusive). The piece channel returns one
// rectangle per request plus is_exact, which is set when the piece is exactly
// A minus B. Both channels use valid and ready; a request or result moves at
// a rising edge where both are high.
// There are three register stages: a geometry stage, a stage with four
// strip-area multipliers, and a ranking stage that feeds the output
// register. An accepted request passes through them in that order, and its
// result is offered from the output register until a receiver takes it.
// Throughput is one request per cycle; the pipeline takes a new request every
// cycle as long as the receiver keeps up.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling; ready drops only when all three are full.
// Reset (arst_n low) empties the pipeline; no result is offered until new
// requests arrive.
`include "assert_macros.svh"

module rect_subtract_largest_piece (
	input  logic                 clk,
	input  logic                 arst_n,
	rsl_pair_if.sink             pair,
	rsl_piece_if.source          piece
);
	import rsl_pkg::*;

	rect_t in_a, in_b;
	geom_t geom;

	// Stage 1: edges and the geometry summary.
	logic  v_s1;
	rect_t a_s1, b_s1;
	geom_t geom_s1;

	// Stage 2: strip areas cross-multiplied so they compare without division.
	logic  v_s2;
	rect_t a_s2, b_s2;
	logic  pass_s2, none_s2, single_s2, lwin_s2, twin_s2;
	prod_t lx_s2, rx_s2, tx_s2, bx_s2;

	// Stage 3: the output register.
	logic  v_s3;
	rect_t out_s3;
	logic  exact_s3;

	logic  adv1, adv2, adv3;
	rect_t res;
	logic  res_exact;

	// A stage may load when it is empty or when the one after it moves on.
	assign adv3 = !v_s3 || piece.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign pair.ready = adv1;

	assign in_a.left   = coord_in(pair.a_left);
	assign in_a.top    = coord_in(pair.a_top);
	assign in_a.right  = coord_in(pair.a_right);
	assign in_a.bottom = coord_in(pair.a_bottom);
	assign in_b.left   = coord_in(pair.b_left);
	assign in_b.top    = coord_in(pair.b_top);
	assign in_b.right  = coord_in(pair.b_right);
	assign in_b.bottom = coord_in(pair.b_bottom);

	rsl_geom u_geom (
		.a    (in_a),
		.b    (in_b),
		.geom (geom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= pair.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pair.valid) begin
			a_s1    <= in_a;
			b_s1    <= in_b;
			geom_s1 <= geom;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			pass_s2   <= geom_s1.pass;
			none_s2   <= geom_s1.none;
			single_s2 <= geom_s1.single;
			lwin_s2   <= geom_s1.nl > geom_s1.nr;
			twin_s2   <= geom_s1.nt > geom_s1.nb;
			// A left or right strip scales with A's height, a top or bottom
			// strip with A's width.
			lx_s2     <= PROD_BITS'(geom_s1.nl) * PROD_BITS'(geom_s1.ah);
			rx_s2     <= PROD_BITS'(geom_s1.nr) * PROD_BITS'(geom_s1.ah);
			tx_s2     <= PROD_BITS'(geom_s1.nt) * PROD_BITS'(geom_s1.aw);
			bx_s2     <= PROD_BITS'(geom_s1.nb) * PROD_BITS'(geom_s1.aw);
		end
	end

	// Ranking: left wins only if it beats right and both horizontal strips, then
	// right over the horizontal strips, then top over bottom. Every tie falls
	// through to the later candidate.
	always_comb begin
		res       = a_s2;
		res_exact = 1'b1;
		if (pass_s2) begin
			if (none_s2) begin
				res = '0;
			end else begin
				res_exact = single_s2;
				if (lwin_s2 && (lx_s2 > tx_s2) && (lx_s2 > bx_s2)) begin
					res.right = b_s2.left;
				end else if ((rx_s2 > tx_s2) && (rx_s2 > bx_s2)) begin
					res.left = b_s2.right;
				end else if (twin_s2) begin
					res.bottom = b_s2.top;
				end else begin
					res.top = b_s2.bottom;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			out_s3   <= res;
			exact_s3 <= res_exact;
		end
	end

	assign piece.valid      = v_s3;
	assign piece.out_left   = coord_out(out_s3.left);
	assign piece.out_top    = coord_out(out_s3.top);
	assign piece.out_right  = coord_out(out_s3.right);
	assign piece.out_bottom = coord_out(out_s3.bottom);
	assign piece.is_exact   = exact_s3;

	// A pair where B covers A must come out as the all-zero exact rectangle.
	`ASSERT_NEXT(a_covered_zero, clk, arst_n, v_s2 && adv3 && pass_s2 && none_s2, piece.valid && piece.is_exact && piece.out_left == '0 && piece.out_top == '0 && piece.out_right == '0 && piece.out_bottom == '0, "covered pair did not give the zero rectangle")

	// A partial piece is always one of the non-empty strips of A.
	`ASSERT_IMPLY(a_partial_nonempty, clk, arst_n, piece.valid && !piece.is_exact, (piece.out_right > piece.out_left) && (piece.out_bottom > piece.out_top), "partial piece is empty")

	// With every stage full and the receiver stalled, no request may enter.
	`ASSERT_IMPLY(a_full_blocks, clk, arst_n, v_s1 && v_s2 && v_s3 && !piece.ready, !pair.ready, "request accepted into a full pipeline")

endmodule

// ===== tb/piece_checker.sv =====
`timescale 1ns / 1ps

module piece_checker (
	input  logic clk,
	input  logic arst_n,
	rsl_pair_if  pair,
	rsl_piece_if piece,
	output int   failures,
	output int   pending,
	output int   compared
);
	import rsl_pkg::*;

	typedef struct {
		io_t  left;
		io_t  top;
		io_t  right;
		io_t  bottom;
		logic exact;
	} piece_t;

	piece_t expected_pieces[$];
	int     fail_count = 0;
	int     pending_count = 0;
	int     compared_count = 0;

	assign failures = fail_count;
	assign pending  = pending_count;
	assign compared = compared_count;

	// The block only looks at the low COORD_BITS bits of each edge.
	function automatic longint to_coord(input io_t raw);
		coord_t c;
		c = raw[COORD_BITS-1:0];
		return longint'(c);
	endfunction

	function automatic io_t to_io(input longint v);
		coord_t c;
		io_t    r;
		c = v[COORD_BITS-1:0];
		r = c;
		return r;
	endfunction

	function automatic bit empty_rect(input longint l, t, r, b, lim);
		return (r - l <= 0) || (b - t <= 0) || (r - l > lim) || (b - t > lim);
	endfunction

	function automatic piece_t largest_piece(input io_t al_raw, at_raw, ar_raw, ab_raw,
		bl_raw, bt_raw, br_raw, bb_raw);
		longint          lim;
		longint          al, at, ar, ab, bl, bt, br, bb;
		longint          pl, pt, pr, pb;
		longint unsigned aw, ah, nl, nr, nt, nb;
		longint unsigned lx, rx, tx, bx;
		int              strips;
		bit              overlap;
		piece_t          res;
		lim = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		al = to_coord(al_raw);
		at = to_coord(at_raw);
		ar = to_coord(ar_raw);
		ab = to_coord(ab_raw);
		bl = to_coord(bl_raw);
		bt = to_coord(bt_raw);
		br = to_coord(br_raw);
		bb = to_coord(bb_raw);
		pl = al;
		pt = at;
		pr = ar;
		pb = ab;
		res.exact = 1'b1;
		overlap = ((al > bl ? al : bl) < (ar < br ? ar : br)) &&
			((at > bt ? at : bt) < (ab < bb ? ab : bb));
		if (!empty_rect(al, at, ar, ab, lim) && !empty_rect(bl, bt, br, bb, lim) && overlap) begin
			aw = longint'(ar - al);
			ah = longint'(ab - at);
			nl = 0;
			nr = 0;
			nt = 0;
			nb = 0;
			strips = 0;
			if (bl > al) begin
				nl = bl - al;
				strips++;
			end
			if (ar > br) begin
				nr = ar - br;
				strips++;
			end
			if (bt > at) begin
				nt = bt - at;
				strips++;
			end
			if (ab > bb) begin
				nb = ab - bb;
				strips++;
			end
			if (strips == 0) begin
				pl = 0;
				pt = 0;
				pr = 0;
				pb = 0;
			end else begin
				// Side strips scale with height/ah, top and bottom with width/aw.
				lx = nl * ah;
				rx = nr * ah;
				tx = nt * aw;
				bx = nb * aw;
				if (nl > nr && lx > tx && lx > bx)
					pr = bl;
				else if (rx > tx && rx > bx)
					pl = br;
				else if (nt > nb)
					pb = bt;
				else
					pt = bb;
				res.exact = (strips == 1);
			end
		end
		res.left   = to_io(pl);
		res.top    = to_io(pt);
		res.right  = to_io(pr);
		res.bottom = to_io(pb);
		return res;
	endfunction

	always @(posedge clk) begin
		piece_t want;
		if (arst_n) begin
			if (pair.valid && pair.ready)
				expected_pieces.push_back(largest_piece(pair.a_left, pair.a_top, pair.a_right,
					pair.a_bottom, pair.b_left, pair.b_top, pair.b_right, pair.b_bottom));
			if (piece.valid && piece.ready) begin
				if (expected_pieces.size() == 0) begin
					$error("piece returned with no request outstanding");
					fail_count++;
				end else begin
					want = expected_pieces.pop_front();
					compared_count++;
					if (piece.out_left !== want.left) begin
						$error("out_left: expected %0d, got %0d", want.left, piece.out_left);
						fail_count++;
					end
					if (piece.out_top !== want.top) begin
						$error("out_top: expected %0d, got %0d", want.top, piece.out_top);
						fail_count++;
					end
					if (piece.out_right !== want.right) begin
						$error("out_right: expected %0d, got %0d", want.right, piece.out_right);
						fail_count++;
					end
					if (piece.out_bottom !== want.bottom) begin
						$error("out_bottom: expected %0d, got %0d", want.bottom,
							piece.out_bottom);
						fail_count++;
					end
					if (piece.is_exact !== want.exact) begin
						$error("is_exact: expected %0d, got %0d", want.exact, piece.is_exact);
						fail_count++;
					end
				end
			end
			pending_count = expected_pieces.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import rsl_pkg::*;

	localparam io_t    CMIN         = 32'sh8000_0000;
	localparam io_t    CMAX         = 32'sh7fff_ffff;
	localparam int     RANDOM_PAIRS = 530;
	// The receiver stops for this many cycles once, after HOLD_AFTER requests.
	localparam int     LONG_HOLD    = 100;
	localparam int     HOLD_AFTER   = 200;
	// The tail follows the last returned piece and leaves ample margin.
	localparam int     TAIL_CYCLES  = 20;
	localparam longint TIMEOUT_NS   = 5_000_000;

	logic clk;
	logic arst_n;
	int   pairs_sent = 0;
	int   directed_pairs = 0;
	int   input_stalls = 0;
	bit   long_hold_done = 1'b0;
	int   failures;
	int   pending;
	int   compared;

	rsl_pair_if  pair ();
	rsl_piece_if piece ();

	rect_subtract_largest_piece DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.piece  (piece)
	);

	piece_checker piece_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.piece    (piece),
		.failures (failures),
		.pending  (pending),
		.compared (compared)
	);

	// Directed rectangle pairs, A then B, each as left, top, right, bottom.
	// They walk through the disjoint and touching cases, empty rectangles of
	// every kind (zero, inverted and too large in each direction), B covering
	// or equal to A, each single strip, each strip winning a ranking, the tie
	// rules, and coordinates at the ends of the signed range.
	io_t directed_cases [24][8] = '{
		'{0, 0, 10, 10, 20, 20, 30, 30},
		'{0, 0, 10, 10, 10, 0, 20, 10},
		'{5, 0, 5, 10, 0, 0, 20, 20},
		'{10, 10, 0, 0, 0, 0, 20, 20},
		'{CMIN, 0, CMAX, 10, 0, 0, 5, 5},
		'{0, 0, 10, 10, 0, 5, 20, 5},
		'{0, 0, 10, 10, 0, CMIN, 5, CMAX},
		'{2, 2, 8, 8, 0, 0, 10, 10},
		'{-3, -3, 7, 7, -3, -3, 7, 7},
		'{0, 0, 10, 10, 4, -5, 20, 20},
		'{0, 0, 10, 10, -5, -5, 6, 20},
		'{0, 0, 10, 10, -5, 3, 20, 20},
		'{0, 0, 10, 10, -5, -5, 20, 7},
		'{0, 0, 9, 9, 3, 3, 6, 6},
		'{0, 0, 20, 10, 12, 2, 15, 8},
		'{0, 0, 20, 10, 2, 2, 5, 8},
		'{0, 0, 10, 20, 2, 12, 8, 15},
		'{0, 0, 10, 20, 2, 2, 8, 5},
		'{0, 0, 10, 10, 4, -5, 6, 20},
		'{CMIN, CMIN, -1, -1, CMIN + 1, CMIN + 1, -2, -2},
		'{0, 0, CMAX, CMAX, 1, 1, 2, CMAX - 1},
		'{-1, -1, 0, 0, -1, -1, 0, 0},
		'{CMAX - 1, CMAX - 1, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX},
		'{0, 0, 10, 10, 0, 2, 10, 8}
	};

	// The clock runs free from time zero.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Reset is held low from time zero and released on a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Counts cycles in which a request waits because the block is full.
	always @(posedge clk)
		if (arst_n && pair.valid && !pair.ready)
			input_stalls++;

	// Picks an idle length from one of three ranges; the shortest range is the
	// most likely and the longest the least likely.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic io_t corner_value();
		case ($urandom_range(0, 8))
			0: return CMIN;
			1: return CMIN + 1;
			2: return -2;
			3: return -1;
			4: return 0;
			5: return 1;
			6: return 2;
			7: return CMAX - 1;
			default: return CMAX;
		endcase
	endfunction

	// Picks a well-formed span (at least one unit wide) inside a window.
	function automatic void place_edges(input io_t base, input int unsigned win,
		output io_t lo, output io_t hi);
		int unsigned p, q, t;
		p = $urandom_range(0, win);
		q = $urandom_range(0, win);
		if (p > q) begin
			t = p;
			p = q;
			q = t;
		end
		lo = base + io_t'(p);
		hi = base + io_t'(q) + 1;
	endfunction

	// Offers one request at a falling edge and holds it until the block takes
	// it. When called back to back, valid simply stays high.
	task automatic send_pair(input io_t v[8]);
		@(negedge clk);
		pair.valid    <= 1'b1;
		pair.a_left   <= v[0];
		pair.a_top    <= v[1];
		pair.a_right  <= v[2];
		pair.a_bottom <= v[3];
		pair.b_left   <= v[4];
		pair.b_top    <= v[5];
		pair.b_right  <= v[6];
		pair.b_bottom <= v[7];
		do
			@(posedge clk);
		while (!pair.ready);
		pairs_sent++;
	endtask

	// After an accepted request the sender may go quiet for a while. In a
	// smooth stretch it never does.
	task automatic pause_sender(input bit smooth);
		int gap;
		gap = 0;
		if (!smooth && $urandom_range(0, 99) < 35)
			gap = idle_length();
		if (gap > 0) begin
			@(negedge clk);
			pair.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Most random pairs share a window, so A and B usually overlap and the
	// strip ranking gets exercised. Small windows give many ties; large ones
	// push the area products toward their full width. A few pairs are fully
	// random or built from range corners, and some well-formed pairs are then
	// broken by swapping a pair of their edges or scrambling one edge.
	task automatic send_random_pair();
		io_t         v[8];
		io_t         base_x, base_y, t;
		int unsigned win;
		int          kind, k;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			foreach (v[i])
				v[i] = $urandom;
		end else if (kind == 1) begin
			foreach (v[i])
				v[i] = corner_value();
		end else begin
			if (kind <= 4) begin
				win = $urandom_range(1, 1 << 30);
				base_x = io_t'($urandom) >>> 2;
				base_y = io_t'($urandom) >>> 2;
			end else begin
				win = $urandom_range(1, 24);
				base_x = $urandom;
				base_y = $urandom;
			end
			place_edges(base_x, win, v[0], v[2]);
			place_edges(base_y, win, v[1], v[3]);
			place_edges(base_x, win, v[4], v[6]);
			place_edges(base_y, win, v[5], v[7]);
			if (kind == 18) begin
				k = $urandom_range(0, 5);
				t = v[k];
				v[k] = v[k + 2];
				v[k + 2] = t;
			end else if (kind == 19) begin
				v[$urandom_range(0, 7)] = $urandom;
			end
		end
		send_pair(v);
	endtask

	// The receiver takes results in stretches of full speed and stretches
	// with random stalls. Once, after enough requests, it stops for a long
	// time while the sender keeps offering, so the pipeline fills and the
	// block has to push back on its input.
	initial begin : piece_receiver
		int hold;
		int cycle;
		piece.ready = 1'b0;
		hold = 0;
		cycle = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cycle++;
			if (!long_hold_done && pairs_sent >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				piece.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (hold > 0) begin
				hold--;
				piece.ready <= 1'b0;
			end else if ((cycle / 150) % 3 != 0 && $urandom_range(0, 99) < 30) begin
				hold = idle_length() - 1;
				piece.ready <= 1'b0;
			end else begin
				piece.ready <= 1'b1;
			end
		end
	end

	// Request stream: the directed pairs first, then the random ones, then
	// wait for every piece to come back and give the verdict.
	initial begin : pair_sender
		pair.valid    = 1'b0;
		pair.a_left   = '0;
		pair.a_top    = '0;
		pair.a_right  = '0;
		pair.a_bottom = '0;
		pair.b_left   = '0;
		pair.b_top    = '0;
		pair.b_right  = '0;
		pair.b_bottom = '0;
		wait (arst_n === 1'b1);
		foreach (directed_cases[i]) begin
			send_pair(directed_cases[i]);
			pause_sender(1'b0);
		end
		directed_pairs = pairs_sent;
		repeat (RANDOM_PAIRS) begin
			send_random_pair();
			// One block of 64 requests in every four goes without sender gaps.
			pause_sender(((pairs_sent / 64) % 4) == 1);
		end
		@(negedge clk);
		pair.valid <= 1'b0;
		wait (pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d rectangle pairs (%0d directed) and checked %0d pieces.",
			pairs_sent, directed_pairs, compared);
		$display("Requests waited %0d cycles on a full pipeline, including a %0d-cycle hold.",
			input_stalls, LONG_HOLD);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin : run_limit
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
